@@ hw/rtl/lhe_pkg.sv @@
// Shared types, codes and reset values for the link health escalation block.
// No dependencies; compile first.
`default_nettype none

package lhe_pkg;

  localparam int NOW_W  = 32;
  localparam int CNT_W  = 8;
  localparam int TIME_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [1:0]            hcode_t;

  // register indexes
  localparam cfg_idx_t REG_HEALTHY_IVL = 3'd0;
  localparam cfg_idx_t REG_SUSPECT_IVL = 3'd1;
  localparam cfg_idx_t REG_FAIL_THR    = 3'd2;
  localparam cfg_idx_t REG_DEG_TMO     = 3'd3;
  localparam cfg_idx_t REG_KICK_SETTLE = 3'd4;
  localparam cfg_idx_t REG_KICKED_TMO  = 3'd5;

  // reset values
  localparam logic [TIME_W-1:0] RST_HEALTHY_IVL = 16'd30;
  localparam logic [TIME_W-1:0] RST_SUSPECT_IVL = 16'd10;
  localparam logic [CNT_W-1:0]  RST_FAIL_THR    = 8'd2;
  localparam logic [TIME_W-1:0] RST_DEG_TMO     = 16'd60;
  localparam logic [TIME_W-1:0] RST_KICK_SETTLE = 16'd15;
  localparam logic [TIME_W-1:0] RST_KICKED_TMO  = 16'd60;
  // last probe at -20 s so the first probe lands at 10 s
  localparam logic [NOW_W-1:0]  RST_LAST_PROBE  = 32'hFFFF_FFEC;
  localparam logic [CNT_W-1:0]  FAIL_MAX        = 8'hFF;

  // external health_state codes
  localparam hcode_t HS_HEALTHY  = 2'd0;
  localparam hcode_t HS_DEGRADED = 2'd1;
  localparam hcode_t HS_KICKED   = 2'd2;
  localparam hcode_t HS_DEAD     = 2'd3;

  typedef enum logic [3:0] {
    ST_HEALTHY  = 4'b0001,
    ST_DEGRADED = 4'b0010,
    ST_KICKED   = 4'b0100,
    ST_DEAD     = 4'b1000
  } state_t;

  function automatic hcode_t state_code(input state_t st);
    hcode_t c;
    case (st)
      ST_HEALTHY:  c = HS_HEALTHY;
      ST_DEGRADED: c = HS_DEGRADED;
      ST_KICKED:   c = HS_KICKED;
      ST_DEAD:     c = HS_DEAD;
      default:     c = HS_HEALTHY;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lhe_if.sv @@
// Valid/ready channel interfaces for ticks and results.
// Depends on lhe_pkg for field widths.
`default_nettype none

interface lhe_in_if;
  logic                      valid;
  logic                      ready;
  logic [lhe_pkg::NOW_W-1:0] now_seconds;
  logic                      probe_ok;

  modport source (output valid, output now_seconds, output probe_ok, input ready);
  modport sink   (input valid, input now_seconds, input probe_ok, output ready);
endinterface

interface lhe_out_if;
  logic                      valid;
  logic                      ready;
  logic                      probe_taken;
  logic                      kick_request;
  logic [1:0]                health_state;
  logic [lhe_pkg::CNT_W-1:0] failure_count;

  modport source (output valid, output probe_taken, output kick_request,
                  output health_state, output failure_count, input ready);
  modport sink   (input valid, input probe_taken, input kick_request,
                  input health_state, input failure_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/link_health_escalation_fsm.sv @@
// Link health watchdog: healthy / degraded / kicked / dead escalation.
// A tick passes through the input register and then the result register.
// Takes one tick per cycle while the result channel is not stalled; the state
// registers update once per tick as it moves into the result register.
// Reset (rst_n, synchronous): config to defaults, state healthy, no failures.
// Depends on lhe_pkg and lhe_if.
`default_nettype none

module link_health_escalation_fsm (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  lhe_pkg::cfg_idx_t    cfg_index,
  input  lhe_pkg::cfg_data_t   cfg_wdata,
  lhe_in_if.sink               in_ch,
  lhe_out_if.source            out_ch
);
  import lhe_pkg::*;

  // configuration
  logic [TIME_W-1:0] healthy_ivl_r, suspect_ivl_r, deg_tmo_r, settle_r, kicked_tmo_r;
  logic [CNT_W-1:0]  fail_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      healthy_ivl_r <= RST_HEALTHY_IVL;
      suspect_ivl_r <= RST_SUSPECT_IVL;
      fail_thr_r    <= RST_FAIL_THR;
      deg_tmo_r     <= RST_DEG_TMO;
      settle_r      <= RST_KICK_SETTLE;
      kicked_tmo_r  <= RST_KICKED_TMO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEALTHY_IVL: healthy_ivl_r <= cfg_wdata;
        REG_SUSPECT_IVL: suspect_ivl_r <= cfg_wdata;
        REG_FAIL_THR:    fail_thr_r    <= cfg_wdata[CNT_W-1:0];
        REG_DEG_TMO:     deg_tmo_r     <= cfg_wdata;
        REG_KICK_SETTLE: settle_r      <= cfg_wdata;
        REG_KICKED_TMO:  kicked_tmo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             s1_valid_r;
  logic [NOW_W-1:0] s1_now_r;
  logic             s1_ok_r;
  logic             out_valid_r;
  logic             s1_adv;
  logic             in_take;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= in_ch.now_seconds;
      s1_ok_r  <= in_ch.probe_ok;
    end
  end

  // escalation state
  state_t           state_r, state_mid, state_nxt;
  logic [NOW_W-1:0] entered_r, entered_nxt;
  logic [NOW_W-1:0] last_probe_r, last_probe_nxt;
  logic [CNT_W-1:0] fail_r, fail_nxt;
  logic [NOW_W-1:0] dwell, dwell_mid, since;
  logic [TIME_W-1:0] interval;
  logic             probe, kick;

  always_comb begin
    dwell    = s1_now_r - entered_r;
    since    = s1_now_r - last_probe_r;
    interval = (fail_r != '0) ? suspect_ivl_r : healthy_ivl_r;

    case (state_r)
      ST_HEALTHY, ST_DEGRADED: probe = since >= {{(NOW_W-TIME_W){1'b0}}, interval};
      ST_KICKED: probe = (dwell >= {{(NOW_W-TIME_W){1'b0}}, settle_r}) &&
                         (since >= {{(NOW_W-TIME_W){1'b0}}, suspect_ivl_r});
      default:   probe = 1'b0;
    endcase

    state_mid      = state_r;
    fail_nxt       = fail_r;
    last_probe_nxt = last_probe_r;
    if (probe) begin
      last_probe_nxt = s1_now_r;
      if (s1_ok_r) begin
        fail_nxt  = '0;
        state_mid = ST_HEALTHY;
      end else begin
        fail_nxt = (fail_r == FAIL_MAX) ? fail_r : fail_r + 1'b1;
        if (state_r == ST_HEALTHY && fail_nxt >= fail_thr_r) state_mid = ST_DEGRADED;
      end
    end

    // a state entered by the probe has zero dwell
    dwell_mid = (state_mid != state_r) ? '0 : dwell;

    state_nxt = state_mid;
    kick      = 1'b0;
    case (state_mid)
      ST_DEGRADED: begin
        if (dwell_mid >= {{(NOW_W-TIME_W){1'b0}}, deg_tmo_r}) begin
          kick      = 1'b1;
          state_nxt = ST_KICKED;
        end
      end
      ST_KICKED: begin
        if (dwell_mid >= {{(NOW_W-TIME_W){1'b0}}, kicked_tmo_r}) state_nxt = ST_DEAD;
      end
      default: ;
    endcase

    entered_nxt = (state_nxt != state_r) ? s1_now_r : entered_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HEALTHY;
      entered_r    <= '0;
      last_probe_r <= RST_LAST_PROBE;
      fail_r       <= '0;
    end else if (s1_adv) begin
      state_r      <= state_nxt;
      entered_r    <= entered_nxt;
      last_probe_r <= last_probe_nxt;
      fail_r       <= fail_nxt;
    end
  end

  // result register
  logic             res_probe_r, res_kick_r;
  hcode_t           res_state_r;
  logic [CNT_W-1:0] res_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_probe_r <= probe;
      res_kick_r  <= kick;
      res_state_r <= state_code(state_nxt);
      res_fail_r  <= fail_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.probe_taken   = res_probe_r;
  assign out_ch.kick_request  = res_kick_r;
  assign out_ch.health_state  = res_state_r;
  assign out_ch.failure_count = res_fail_r;

endmodule

`default_nettype wire

@@ hw/rtl/lhe_checker.sv @@
// Port-level assertions for link_health_escalation_fsm, with its bind.
// Depends on lhe_pkg for state codes.
`default_nettype none

module lhe_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire                      out_probe_taken,
  input wire                      out_kick_request,
  input wire [1:0]                out_health_state,
  input wire [lhe_pkg::CNT_W-1:0] out_failure_count
);
  import lhe_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a kick lands in kicked and only follows counted failures
  a_kick_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kick_request) |->
      (out_health_state == HS_KICKED && out_failure_count != '0))
    else $error("kick without kicked state or failures");

  // dead is terminal
  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_health_state == HS_DEAD) |=>
      (!out_valid || out_health_state == HS_DEAD))
    else $error("left dead state");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_probe_taken) && $stable(out_kick_request) &&
       $stable(out_health_state) && $stable(out_failure_count)))
    else $error("stalled result changed");

endmodule

bind link_health_escalation_fsm lhe_checker u_lhe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_probe_taken   (out_ch.probe_taken),
  .out_kick_request  (out_ch.kick_request),
  .out_health_state  (out_ch.health_state),
  .out_failure_count (out_ch.failure_count)
);

`default_nettype wire

@@ test/link_health_checker.sv @@
// Passive checker for the link health watchdog: mirrors register writes,
// predicts every tick result and compares it with what the block returns.
// Depends on lhe_pkg and lhe_if.
`timescale 1ns / 100ps

module link_health_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  lhe_pkg::cfg_idx_t  cfg_index,
  input  lhe_pkg::cfg_data_t cfg_wdata,
  lhe_in_if                  in_ch,
  lhe_out_if                 out_ch,
  output int                 fail_count,
  output int                 pending_results,
  output lhe_pkg::hcode_t    predicted_state,
  output int                 checked_count,
  output int                 probe_count,
  output int                 kick_count,
  output int                 dead_count
);
  import lhe_pkg::*;

  typedef struct packed {
    logic             probe_taken;
    logic             kick_request;
    hcode_t           health_state;
    logic [CNT_W-1:0] failure_count;
  } health_report_t;

  health_report_t health_reports_due[$];
  health_report_t want, seen;

  // mirrored registers
  logic [TIME_W-1:0] ivl_healthy, ivl_suspect, tmo_degraded, settle_kick, tmo_kicked;
  logic [CNT_W-1:0]  fail_thr;

  // mirrored watchdog state
  hcode_t            link_state;
  logic [NOW_W-1:0]  entered_at_t, last_probe_t;
  logic [CNT_W-1:0]  fail_cnt;

  task automatic move_to(input hcode_t next, input logic [NOW_W-1:0] now);
    if (link_state != next) begin
      link_state   = next;
      entered_at_t = now;
    end
  endtask

  task automatic advance_watchdog(input logic [NOW_W-1:0] now, input logic ok,
                                  output health_report_t res);
    logic [NOW_W-1:0] dwell, since, ivl;
    logic             probe, kick;
    dwell = now - entered_at_t;
    since = now - last_probe_t;
    ivl   = (fail_cnt != '0) ? {16'b0, ivl_suspect} : {16'b0, ivl_healthy};
    probe = 1'b0;
    kick  = 1'b0;

    if (link_state == HS_HEALTHY || link_state == HS_DEGRADED) begin
      probe = (since >= ivl);
    end else if (link_state == HS_KICKED) begin
      // settle gate uses the dwell from the start of the tick
      probe = (dwell >= {16'b0, settle_kick}) && (since >= {16'b0, ivl_suspect});
    end

    if (probe) begin
      last_probe_t = now;
      if (ok) begin
        fail_cnt = '0;
        move_to(HS_HEALTHY, now);
      end else begin
        if (fail_cnt != FAIL_MAX) fail_cnt = fail_cnt + 8'd1;
        if (link_state == HS_HEALTHY && fail_cnt >= fail_thr) move_to(HS_DEGRADED, now);
      end
    end

    // escalation dwell counts from the latest entry, this tick included
    dwell = now - entered_at_t;
    if (link_state == HS_DEGRADED) begin
      if (dwell >= {16'b0, tmo_degraded}) begin
        kick = 1'b1;
        move_to(HS_KICKED, now);
      end
    end else if (link_state == HS_KICKED) begin
      if (dwell >= {16'b0, tmo_kicked}) move_to(HS_DEAD, now);
    end

    res.probe_taken   = probe;
    res.kick_request  = kick;
    res.health_state  = link_state;
    res.failure_count = fail_cnt;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ivl_healthy  = RST_HEALTHY_IVL;
      ivl_suspect  = RST_SUSPECT_IVL;
      fail_thr     = RST_FAIL_THR;
      tmo_degraded = RST_DEG_TMO;
      settle_kick  = RST_KICK_SETTLE;
      tmo_kicked   = RST_KICKED_TMO;
      link_state   = HS_HEALTHY;
      entered_at_t = '0;
      last_probe_t = RST_LAST_PROBE;
      fail_cnt     = '0;
      health_reports_due.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_HEALTHY_IVL: ivl_healthy  = cfg_wdata;
          REG_SUSPECT_IVL: ivl_suspect  = cfg_wdata;
          REG_FAIL_THR:    fail_thr     = cfg_wdata[CNT_W-1:0];
          REG_DEG_TMO:     tmo_degraded = cfg_wdata;
          REG_KICK_SETTLE: settle_kick  = cfg_wdata;
          REG_KICKED_TMO:  tmo_kicked   = cfg_wdata;
          default: ;
        endcase
      end

      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.probe_taken   = out_ch.probe_taken;
        seen.kick_request  = out_ch.kick_request;
        seen.health_state  = out_ch.health_state;
        seen.failure_count = out_ch.failure_count;
        if (health_reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no tick outstanding: probe=%b kick=%b state=%0d fails=%0d",
                     $time, seen.probe_taken, seen.kick_request, seen.health_state,
                     seen.failure_count);
        end else begin
          want = health_reports_due.pop_front();
          checked_count++;
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: result %0d wrong: want probe=%b kick=%b state=%0d fails=%0d, %s",
                       $time, checked_count, want.probe_taken, want.kick_request,
                       want.health_state, want.failure_count,
                       $sformatf("got probe=%b kick=%b state=%0d fails=%0d",
                                 seen.probe_taken, seen.kick_request, seen.health_state,
                                 seen.failure_count));
          end
        end
      end

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        advance_watchdog(in_ch.now_seconds, in_ch.probe_ok, want);
        health_reports_due.push_back(want);
        if (want.probe_taken) probe_count++;
        if (want.kick_request) kick_count++;
        if (want.health_state == HS_DEAD) dead_count++;
      end
    end
    pending_results = health_reports_due.size();
    predicted_state = link_state;
  end

endmodule

@@ test/tb_link_health_escalation_fsm.sv @@
// Testbench top for the link health watchdog: clock, reset, tick stimulus,
// register programming and verdict; checking lives in link_health_checker.
// Depends on lhe_pkg, lhe_if, link_health_escalation_fsm and link_health_checker.
`timescale 1ns / 100ps

module tb_link_health_escalation_fsm;
  import lhe_pkg::*;

  localparam int       STALL_LIMIT  = 2000;
  // indexes past the last register; writes there must be dropped
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  lhe_in_if  in_ch();
  lhe_out_if out_ch();

  int     fail_count, pending_results, checked_count;
  int     probe_count, kick_count, dead_count;
  hcode_t predicted_state;

  int               send_idle_pct, recv_idle_pct, rx_hold_req;
  int               stall_cycles, ticks_sent, settings_used, step_max;
  logic [NOW_W-1:0] tick_now;

  link_health_escalation_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  link_health_checker health_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .predicted_state (predicted_state),
    .checked_count   (checked_count),
    .probe_count     (probe_count),
    .kick_count      (kick_count),
    .dead_count      (dead_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // probe outcome steered by the predicted state (one tick stale): fail often
  // in degraded to reach the kick, recover almost always in kicked
  function automatic logic pick_ok(input hcode_t st);
    logic ok;
    case (st)
      HS_DEGRADED: ok = ($urandom_range(0, 3) == 0);
      HS_KICKED:   ok = ($urandom_range(0, 15) != 0);
      default:     ok = ($urandom_range(0, 1) == 1);
    endcase
    return ok;
  endfunction

  task automatic send_tick(input logic [NOW_W-1:0] t, input logic ok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.now_seconds <= t;
    in_ch.probe_ok    <= ok;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    ticks_sent++;
  endtask

  // mostly forward time in small steps; some wild, backward and long jumps.
  // Off-pattern ticks report success so that a huge dwell cannot end in dead.
  task automatic send_random_ticks(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        tick_now = $urandom;
        send_tick(tick_now, 1'b1);
      end else if (r < 8) begin
        tick_now = tick_now - $urandom_range(1, 50);
        send_tick(tick_now, 1'b1);
      end else if (r < 12) begin
        tick_now = tick_now + $urandom_range(100, 70000);
        send_tick(tick_now, 1'b1);
      end else begin
        tick_now = tick_now + $urandom_range(0, step_max);
        send_tick(tick_now, pick_ok(predicted_state));
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    // covers the two-stage pipeline
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input cfg_data_t h_ivl, input cfg_data_t s_ivl,
                              input cfg_data_t thr, input cfg_data_t deg,
                              input cfg_data_t settle, input cfg_data_t kto);
    wait_drained();
    write_reg(REG_SPARE_LO, cfg_data_t'($urandom));
    write_reg(REG_HEALTHY_IVL, h_ivl);
    write_reg(REG_SUSPECT_IVL, s_ivl);
    write_reg(REG_FAIL_THR, thr);
    write_reg(REG_DEG_TMO, deg);
    write_reg(REG_KICK_SETTLE, settle);
    write_reg(REG_KICKED_TMO, kto);
    write_reg(REG_SPARE_HI, cfg_data_t'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // receiver: random back-pressure, or a long hold when one is requested
  initial begin
    int hold_len;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_len    = rx_hold_req;
        rx_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[link_health_escalation_fsm] ERROR");
      $finish;
    end
  end

  initial begin
    int        s_ivl, settle, span;
    cfg_data_t thr_word;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_HEALTHY_IVL;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.now_seconds = '0;
    in_ch.probe_ok    = 1'b0;
    send_idle_pct     = 25;
    recv_idle_pct     = 72;
    step_max          = 12;
    tick_now          = '0;
    settings_used     = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: 30 s / 10 s intervals, threshold 2, timeouts 60/15/60
    send_tick(32'd0, 1'b1);          // before the first probe; outcome unused
    send_tick(32'd10, 1'b0);         // first probe lands at 10 s
    send_tick(32'd15, 1'b1);         // suspect interval not yet up
    send_tick(32'd20, 1'b0);         // threshold reached -> degraded
    send_tick(32'd30, 1'b0);
    send_tick(32'd80, 1'b0);         // degraded dwell 60 -> kick
    send_tick(32'd90, 1'b1);         // kicked, still settling
    send_tick(32'd95, 1'b0);         // settle done, failed probe in kicked
    send_tick(32'd105, 1'b1);        // recovery to healthy
    send_tick(32'hFFFF_FFFF, 1'b0);  // top of the time range
    send_tick(32'd5, 1'b0);          // across the wrap, too soon
    send_tick(32'd9, 1'b0);          // across the wrap -> degraded
    send_tick(32'd9, 1'b0);          // same second again
    send_tick(32'd69, 1'b1);         // success beats the kick on the same tick
    send_tick(32'd79, 1'b0);         // back on the healthy interval
    send_tick(32'd99, 1'b0);
    send_tick(32'd109, 1'b0);
    send_tick(32'd169, 1'b0);        // kick again
    send_tick(32'd229, 1'b1);        // probe at the kicked timeout wins
    tick_now = 32'd229;
    send_random_ticks(80);

    // zero intervals and settle, largest threshold and timeouts:
    // a long outage drives the count into saturation
    send_idle_pct = 72;
    recv_idle_pct = 25;
    program_regs(16'd0, 16'd0, 16'd255, 16'hFFFF, 16'd0, 16'hFFFF);
    step_max = 2;
    tick_now = tick_now + 32'd1;
    send_tick(tick_now, 1'b1);
    repeat (262) begin
      tick_now = tick_now + $urandom_range(0, 2);
      send_tick(tick_now, 1'b0);
    end
    tick_now = tick_now + 32'd65535;
    send_tick(tick_now, 1'b0);
    send_random_ticks(20);

    // mid-range random settings, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 3; n++) begin
      s_ivl    = $urandom_range(1, 15);
      settle   = $urandom_range(0, 30);
      span     = settle + 6 * s_ivl + $urandom_range(20, 120);
      // upper byte is junk; only the low byte holds the threshold
      thr_word = cfg_data_t'(($urandom_range(0, 255) << 8) | $urandom_range(1, 4));
      program_regs(cfg_data_t'($urandom_range(1, 40)), cfg_data_t'(s_ivl), thr_word,
                   cfg_data_t'($urandom_range(0, 120)), cfg_data_t'(settle),
                   cfg_data_t'(span));
      step_max = s_ivl + 2;
      if (n == 1) begin
        send_random_ticks(8);
        rx_hold_req = 200;
        send_random_ticks(22);
      end else if (n == 2) begin
        send_random_ticks(15);
        wait_drained();
        send_random_ticks(15);
      end else begin
        send_random_ticks(30);
      end
    end

    // opposite extremes: zero threshold and timeouts end in dead
    program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    tick_now = tick_now + 32'd70000;
    send_tick(tick_now, 1'b1);       // back to healthy
    tick_now = tick_now + 32'd70000;
    send_tick(tick_now, 1'b0);       // one failure -> degraded -> kicked at once
    tick_now = tick_now + 32'd1;
    send_tick(tick_now, 1'b1);       // zero kicked timeout -> dead
    send_random_ticks(10);

    wait_drained();
    $display("covered %0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_used, checked_count);
    $display("predicted %0d probes, %0d kicks, %0d ticks ending dead, %0d mismatches",
             probe_count, kick_count, dead_count, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[link_health_escalation_fsm] OK");
    end else begin
      $display("[link_health_escalation_fsm] ERROR");
    end
    $finish;
  end

endmodule
